// ===== src/x86_twobyte_integer_execute_core_defines.svh =====
// Assertion macros used by the execute core.
`ifndef X86_TWOBYTE_INTEGER_EXECUTE_CORE_DEFINES_SVH
`define X86_TWOBYTE_INTEGER_EXECUTE_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define XTIE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define XTIE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/xtie_pkg.sv =====
package xtie_pkg;

    // Command codes
    localparam logic [4:0] CMD_COND      = 5'd0;
    localparam logic [4:0] CMD_CMOV      = 5'd1;
    localparam logic [4:0] CMD_SETCC     = 5'd2;
    localparam logic [4:0] CMD_BT        = 5'd3;
    localparam logic [4:0] CMD_BTS       = 5'd4;
    localparam logic [4:0] CMD_BTR       = 5'd5;
    localparam logic [4:0] CMD_BTC       = 5'd6;
    localparam logic [4:0] CMD_BSF       = 5'd7;
    localparam logic [4:0] CMD_BSR       = 5'd8;
    localparam logic [4:0] CMD_MOVZX8    = 5'd9;
    localparam logic [4:0] CMD_MOVZX16   = 5'd10;
    localparam logic [4:0] CMD_MOVSX8    = 5'd11;
    localparam logic [4:0] CMD_MOVSX16   = 5'd12;
    localparam logic [4:0] CMD_BSWAP     = 5'd13;
    localparam logic [4:0] CMD_CMPXCHG8  = 5'd14;
    localparam logic [4:0] CMD_CMPXCHG32 = 5'd15;
    localparam logic [4:0] CMD_LOADFLAGS = 5'd16;

    // Flag bit positions
    localparam int unsigned FLAG_CF = 0;
    localparam int unsigned FLAG_PF = 1;
    localparam int unsigned FLAG_ZF = 2;
    localparam int unsigned FLAG_SF = 3;
    localparam int unsigned FLAG_OF = 4;

    // Condition groups (condition nibble without its invert bit)
    localparam logic [2:0] CGRP_O  = 3'd0;
    localparam logic [2:0] CGRP_B  = 3'd1;
    localparam logic [2:0] CGRP_E  = 3'd2;
    localparam logic [2:0] CGRP_BE = 3'd3;
    localparam logic [2:0] CGRP_S  = 3'd4;
    localparam logic [2:0] CGRP_P  = 3'd5;
    localparam logic [2:0] CGRP_L  = 3'd6;
    localparam logic [2:0] CGRP_LE = 3'd7;

    // Bytes of the scanned source
    localparam int unsigned SCAN_BYTES = 4;

    typedef struct packed {
        logic [4:0]  command;
        logic [3:0]  cond_code;
        logic [31:0] dest_value;
        logic [31:0] src_value;
        logic [31:0] accum_value;
        logic [7:0]  bit_index;
        logic        is_memory;
        logic [4:0]  flags_in;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [4:0] pos;
    } scan_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_dest;
        logic [31:0] accum_out;
        logic        write_accum;
        logic        condition_true;
        logic [2:0]  dword_offset;
        logic [4:0]  flags_out;
    } res_t;

endpackage

// ===== src/xtie_scan.sv =====
// One byte of a bit scan: lowest set bit, or highest when from_top is set.
module xtie_scan (
    input  logic [7:0] byte_in,
    input  logic       from_top,
    output logic       hit,
    output logic [2:0] pos
);

    always_comb begin
        hit = |byte_in;
        pos = 3'd0;
        if (from_top) begin
            for (int i = 0; i < 8; i++) begin
                if (byte_in[i]) begin
                    pos = 3'(i);
                end
            end
        end else begin
            for (int i = 7; i >= 0; i--) begin
                if (byte_in[i]) begin
                    pos = 3'(i);
                end
            end
        end
    end

endmodule

// ===== src/xtie_alu.sv =====
// Result and flag formation for one request, given the finished scan.
module xtie_alu (
    input  xtie_pkg::req_t  req,
    input  logic [4:0]      flags,
    input  xtie_pkg::scan_t scan,
    output xtie_pkg::res_t  res
);

    logic        cond_raw;
    logic        cond_true;
    logic        bit_hit;
    logic [31:0] bit_mask;
    logic        byte_form;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [32:0] diff;
    logic [31:0] ovf_vec;
    logic        cmp_equal;
    logic [4:0]  cmp_flags;

    always_comb begin
        case (req.cond_code[3:1])
            xtie_pkg::CGRP_O:  cond_raw = flags[xtie_pkg::FLAG_OF];
            xtie_pkg::CGRP_B:  cond_raw = flags[xtie_pkg::FLAG_CF];
            xtie_pkg::CGRP_E:  cond_raw = flags[xtie_pkg::FLAG_ZF];
            xtie_pkg::CGRP_BE: cond_raw = flags[xtie_pkg::FLAG_ZF] | flags[xtie_pkg::FLAG_CF];
            xtie_pkg::CGRP_S:  cond_raw = flags[xtie_pkg::FLAG_SF];
            xtie_pkg::CGRP_P:  cond_raw = flags[xtie_pkg::FLAG_PF];
            xtie_pkg::CGRP_L:  cond_raw = flags[xtie_pkg::FLAG_SF] ^ flags[xtie_pkg::FLAG_OF];
            default:           cond_raw = flags[xtie_pkg::FLAG_ZF]
                                   | (flags[xtie_pkg::FLAG_SF] ^ flags[xtie_pkg::FLAG_OF]);
        endcase
        cond_true = cond_raw ^ req.cond_code[0];
    end

    assign bit_mask = 32'd1 << req.bit_index[4:0];
    assign bit_hit  = req.dest_value[req.bit_index[4:0]];

    // Compare: accumulator minus destination, byte form zero-extended
    assign byte_form = (req.command == xtie_pkg::CMD_CMPXCHG8);
    assign op_a      = byte_form ? {24'd0, req.accum_value[7:0]} : req.accum_value;
    assign op_b      = byte_form ? {24'd0, req.dest_value[7:0]} : req.dest_value;
    assign diff      = {1'b0, op_a} - {1'b0, op_b};
    assign ovf_vec   = (op_a ^ op_b) & (op_a ^ diff[31:0]);
    assign cmp_equal = byte_form ? (diff[7:0] == 8'd0) : (diff[31:0] == 32'd0);

    always_comb begin
        cmp_flags                    = '0;
        cmp_flags[xtie_pkg::FLAG_CF] = diff[32];
        cmp_flags[xtie_pkg::FLAG_PF] = ~^diff[7:0];
        cmp_flags[xtie_pkg::FLAG_ZF] = cmp_equal;
        cmp_flags[xtie_pkg::FLAG_SF] = byte_form ? diff[7] : diff[31];
        cmp_flags[xtie_pkg::FLAG_OF] = byte_form ? ovf_vec[7] : ovf_vec[31];
    end

    always_comb begin
        res              = '0;
        res.result_value = req.dest_value;
        res.flags_out    = flags;
        case (req.command)
            xtie_pkg::CMD_COND: begin
                res.condition_true = cond_true;
            end
            xtie_pkg::CMD_CMOV: begin
                res.condition_true = cond_true;
                if (cond_true) begin
                    res.result_value = req.src_value;
                    res.write_dest   = 1'b1;
                end
            end
            xtie_pkg::CMD_SETCC: begin
                res.condition_true = cond_true;
                res.result_value   = {31'd0, cond_true};
                res.write_dest     = 1'b1;
            end
            xtie_pkg::CMD_BT, xtie_pkg::CMD_BTS, xtie_pkg::CMD_BTR, xtie_pkg::CMD_BTC: begin
                res.dword_offset               = req.is_memory ? req.bit_index[7:5] : 3'd0;
                res.flags_out[xtie_pkg::FLAG_CF] = bit_hit;
                if (req.command == xtie_pkg::CMD_BTS) begin
                    res.result_value = req.dest_value | bit_mask;
                    res.write_dest   = 1'b1;
                end else if (req.command == xtie_pkg::CMD_BTR) begin
                    res.result_value = req.dest_value & ~bit_mask;
                    res.write_dest   = 1'b1;
                end else if (req.command == xtie_pkg::CMD_BTC) begin
                    res.result_value = req.dest_value ^ bit_mask;
                    res.write_dest   = 1'b1;
                end
            end
            xtie_pkg::CMD_BSF, xtie_pkg::CMD_BSR: begin
                res.flags_out[xtie_pkg::FLAG_ZF] = ~scan.found;
                if (scan.found) begin
                    res.result_value = {27'd0, scan.pos};
                    res.write_dest   = 1'b1;
                end
            end
            xtie_pkg::CMD_MOVZX8: begin
                res.result_value = {24'd0, req.src_value[7:0]};
                res.write_dest   = 1'b1;
            end
            xtie_pkg::CMD_MOVZX16: begin
                res.result_value = {16'd0, req.src_value[15:0]};
                res.write_dest   = 1'b1;
            end
            xtie_pkg::CMD_MOVSX8: begin
                res.result_value = {{24{req.src_value[7]}}, req.src_value[7:0]};
                res.write_dest   = 1'b1;
            end
            xtie_pkg::CMD_MOVSX16: begin
                res.result_value = {{16{req.src_value[15]}}, req.src_value[15:0]};
                res.write_dest   = 1'b1;
            end
            xtie_pkg::CMD_BSWAP: begin
                res.result_value = {req.dest_value[7:0], req.dest_value[15:8],
                                    req.dest_value[23:16], req.dest_value[31:24]};
                res.write_dest   = 1'b1;
            end
            xtie_pkg::CMD_CMPXCHG8: begin
                res.flags_out = cmp_flags;
                if (cmp_equal) begin
                    res.result_value = {24'd0, req.src_value[7:0]};
                    res.write_dest   = 1'b1;
                end else begin
                    res.accum_out   = {req.accum_value[31:8], req.dest_value[7:0]};
                    res.write_accum = 1'b1;
                end
            end
            xtie_pkg::CMD_CMPXCHG32: begin
                res.flags_out = cmp_flags;
                if (cmp_equal) begin
                    res.result_value = req.src_value;
                    res.write_dest   = 1'b1;
                end else begin
                    res.accum_out   = req.dest_value;
                    res.write_accum = 1'b1;
                end
            end
            xtie_pkg::CMD_LOADFLAGS: begin
                res.flags_out = req.flags_in;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/x86_twobyte_integer_execute_core.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// request  | s_valid / s_ready    | s_command, s_cond_code, s_dest_value, s_src_value,
//          |                      | s_accum_value, s_bit_index, s_is_memory, s_flags_in
// result   | m_valid / m_ready    | m_result_value, m_write_dest, m_accum_out,
//          |                      | m_write_accum, m_condition_true, m_dword_offset,
//          |                      | m_flags_out
//
// Sequence: a request passes from idle to done, where its result is registered
// into the output register; BSF and BSR pass through the scan state first, as
// the shared scan unit walks the source one byte per cycle over 4 bytes.
// Reset: synchronous, active low; clears the sequencer, the result valid and the
// flags register (all flags clear).
// Stalls: one request at a time; s_ready is high only while the sequencer idles.
// A result waiting in the output register does not block acceptance; a finished
// request holds in its final state until the output register is free.
`include "x86_twobyte_integer_execute_core_defines.svh"

module x86_twobyte_integer_execute_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_command,
    input  logic [3:0]  s_cond_code,
    input  logic [31:0] s_dest_value,
    input  logic [31:0] s_src_value,
    input  logic [31:0] s_accum_value,
    input  logic [7:0]  s_bit_index,
    input  logic        s_is_memory,
    input  logic [4:0]  s_flags_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value,
    output logic        m_write_dest,
    output logic [31:0] m_accum_out,
    output logic        m_write_accum,
    output logic        m_condition_true,
    output logic [2:0]  m_dword_offset,
    output logic [4:0]  m_flags_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam int unsigned CntW = $clog2(xtie_pkg::SCAN_BYTES);

    state_t           state_reg,  state_next;
    xtie_pkg::req_t   req_reg,    req_next;
    logic [CntW-1:0]  cnt_reg,    cnt_next;
    xtie_pkg::scan_t  scan_reg,   scan_next;
    logic [4:0]       flags_reg,  flags_next;
    logic             m_valid_reg, m_valid_next;
    xtie_pkg::res_t   out_reg,    out_next;

    xtie_pkg::req_t   s_req;
    xtie_pkg::res_t   alu_res;
    logic             accept;
    logic             is_scan_cmd;
    logic             scan_from_top;
    logic [CntW-1:0]  byte_sel;
    logic             byte_hit;
    logic [2:0]       byte_pos;
    logic             out_free;
    logic             commit;

    // Gather the request fields
    always_comb begin
        s_req.command     = s_command;
        s_req.cond_code   = s_cond_code;
        s_req.dest_value  = s_dest_value;
        s_req.src_value   = s_src_value;
        s_req.accum_value = s_accum_value;
        s_req.bit_index   = s_bit_index;
        s_req.is_memory   = s_is_memory;
        s_req.flags_in    = s_flags_in;
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_DONE) && out_free;

    assign is_scan_cmd   = (s_command == xtie_pkg::CMD_BSF) || (s_command == xtie_pkg::CMD_BSR);
    assign scan_from_top = (req_reg.command == xtie_pkg::CMD_BSR);
    // BSR walks from the top byte down, BSF from the bottom up
    assign byte_sel      = scan_from_top ? ~cnt_reg : cnt_reg;

    xtie_scan u_scan (
        .byte_in  (req_reg.src_value[byte_sel*8 +: 8]),
        .from_top (scan_from_top),
        .hit      (byte_hit),
        .pos      (byte_pos)
    );

    xtie_alu u_alu (
        .req   (req_reg),
        .flags (flags_reg),
        .scan  (scan_reg),
        .res   (alu_res)
    );

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        scan_next    = scan_reg;
        flags_next   = flags_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next  = s_req;
                    cnt_next  = '0;
                    scan_next = '0;
                    state_next = is_scan_cmd ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                // Keep the first hit in scan order
                if (!scan_reg.found && byte_hit) begin
                    scan_next.found = 1'b1;
                    scan_next.pos   = {byte_sel, byte_pos};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(xtie_pkg::SCAN_BYTES - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free, then retire
                if (out_free) begin
                    out_next     = alu_res;
                    flags_next   = alu_res.flags_out;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            scan_reg    <= '0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            scan_reg    <= scan_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg <= req_next;
        out_reg <= out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_result_value   = out_reg.result_value;
    assign m_write_dest     = out_reg.write_dest;
    assign m_accum_out      = out_reg.accum_out;
    assign m_write_accum    = out_reg.write_accum;
    assign m_condition_true = out_reg.condition_true;
    assign m_dword_offset   = out_reg.dword_offset;
    assign m_flags_out      = out_reg.flags_out;

    `XTIE_ASSERT(a_busy_after_accept, accept |=> !s_ready, "core took a second request while busy")
    `XTIE_ASSERT(a_flags_only_on_commit, !commit |=> $stable(flags_reg), "flags changed without a retiring request")
    `XTIE_ASSERT(a_commit_sets_valid, commit |=> m_valid_reg && (m_flags_out == flags_reg), "retired result does not match flags")
    `XTIE_ASSERT(a_dest_accum_exclusive, m_valid_reg |-> !(m_write_dest && m_write_accum), "destination and accumulator written together")
    `XTIE_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE) && !m_valid_reg, "reset did not idle the core")

endmodule
